// ----- rtl/aesbe_pkg.sv -----
package aesbe_pkg;

    localparam int NUM_ROUNDS_DEF = 10;
    localparam int COL_W          = 32;
    localparam int BLK_W          = 128;
    localparam logic FUNC_KEY     = 1'b0;
    localparam logic FUNC_ENC     = 1'b1;

    localparam logic [7:0] SBOX [256] = '{
        8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
        8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
        8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
        8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
        8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
        8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
        8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
        8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
        8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
        8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
        8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
        8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
        8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
        8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
        8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
        8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
        8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
        8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
        8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
        8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
        8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
        8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
        8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
        8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
        8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
        8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
        8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
        8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
        8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
        8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
        8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
        8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
    };

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] blk_byte(input logic [BLK_W-1:0] s, input int i);
        return s[BLK_W-1-8*i -: 8];
    endfunction

endpackage

// ----- rtl/aes128_block_encrypt.sv -----
// Channel   Handshake            Payload
// input     i_valid / o_ready    i_func, i_key_*, i_text_*, i_chain_*
// output    o_valid / i_ready    o_cipher_hi, o_cipher_lo
//
// A key word write is written into the key memory as it is accepted. An encrypt
// transfer runs an initial key add and then NUM_ROUNDS rounds, each using the
// round key row from the registered key memory read, issued one step ahead.
// One block at a time; the next input is taken once the core is free, even
// while a ciphertext waits in the output register.
// If the output register is still full when the last round is due, the core
// holds there until it drains. Reset is synchronous; the key memory is not
// cleared and must be loaded before use.
module aes128_block_encrypt
    import aesbe_pkg::*;
#(
    parameter int NUM_ROUNDS = NUM_ROUNDS_DEF,
    localparam int AW = $clog2(NUM_ROUNDS + 1)
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_func,
    input  logic [3:0]  i_key_round,
    input  logic [1:0]  i_key_word,
    input  logic [31:0] i_key_data,
    input  logic [63:0] i_text_hi,
    input  logic [63:0] i_text_lo,
    input  logic [63:0] i_chain_hi,
    input  logic [63:0] i_chain_lo,
    input  logic        i_chain_valid,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [63:0] o_cipher_hi,
    output logic [63:0] o_cipher_lo
);

    logic             r_busy, n_busy;
    logic [AW-1:0]    r_cnt, n_cnt;      // step now using key row r_cnt
    logic [BLK_W-1:0] r_state, n_state;
    logic             r_oval, n_oval;
    logic [BLK_W-1:0] r_out, n_out;

    logic             in_xfer, adv, last, wr_en;
    logic [AW-1:0]    rd_round;
    logic [BLK_W-1:0] key_row, rnd_out, pt;

    assign o_ready = !r_busy;
    assign in_xfer = i_valid && o_ready;
    assign wr_en   = in_xfer && (i_func == FUNC_KEY)
                     && ({1'b0, i_key_round} <= 5'(NUM_ROUNDS));
    assign last    = (r_cnt == AW'(NUM_ROUNDS));
    // last step must find the output register free (or draining)
    assign adv     = r_busy && (!last || !r_oval || i_ready);
    assign rd_round = in_xfer ? '0 : (adv && !last) ? r_cnt + 1'b1 : r_cnt;

    assign pt = {i_text_hi, i_text_lo}
              ^ (i_chain_valid ? {i_chain_hi, i_chain_lo} : {BLK_W{1'b0}});

    aesbe_key_mem #(.NUM_ROUNDS(NUM_ROUNDS)) u_key (
        .i_clk      (i_clk),
        .i_wr_en    (wr_en),
        .i_wr_round (AW'(i_key_round)),
        .i_wr_col   (i_key_word),
        .i_wr_data  (i_key_data),
        .i_rd_round (rd_round),
        .o_rd_data  (key_row)
    );

    aesbe_round u_round (
        .i_state (r_state),
        .i_mix   (!last),
        .i_key   (key_row),
        .o_state (rnd_out)
    );

    always_comb begin
        n_busy  = r_busy;
        n_cnt   = r_cnt;
        n_state = r_state;
        n_oval  = r_oval && !i_ready;
        n_out   = r_out;
        if (in_xfer && i_func == FUNC_ENC) begin
            n_busy  = 1'b1;
            n_cnt   = '0;
            n_state = pt;
        end else if (adv) begin
            if (r_cnt == '0) begin
                n_state = r_state ^ key_row;   // initial key add
                n_cnt   = r_cnt + 1'b1;
            end else if (!last) begin
                n_state = rnd_out;
                n_cnt   = r_cnt + 1'b1;
            end else begin
                n_out  = rnd_out;
                n_oval = 1'b1;
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_oval <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
            r_oval <= n_oval;
        end
        r_state <= n_state;
        r_out   <= n_out;
    end

    assign o_valid     = r_oval;
    assign o_cipher_hi = r_out[BLK_W-1 -: 64];
    assign o_cipher_lo = r_out[63:0];

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_cnt <= AW'(NUM_ROUNDS)))
        else $error("round count out of range");
    a_out_from_core: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_busy))
        else $error("result without a block in flight");
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> $stable(o_cipher_hi) && $stable(o_cipher_lo))
        else $error("pending result overwritten");
    a_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && !last) |=> (r_cnt == $past(r_cnt) + 1'b1))
        else $error("round step lost");
`endif

endmodule

// ----- rtl/aesbe_key_mem.sv -----
module aesbe_key_mem
    import aesbe_pkg::*;
#(
    parameter int NUM_ROUNDS = NUM_ROUNDS_DEF,
    localparam int AW = $clog2(NUM_ROUNDS + 1)
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_round,
    input  logic [1:0]       i_wr_col,
    input  logic [COL_W-1:0] i_wr_data,
    input  logic [AW-1:0]    i_rd_round,
    output logic [BLK_W-1:0] o_rd_data
);

    // one row per round key, columns 0..3 from the top bits down
    logic [BLK_W-1:0] r_mem [NUM_ROUNDS+1];
    logic [BLK_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_round][BLK_W-1-COL_W*i_wr_col -: COL_W] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_round];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- rtl/aesbe_round.sv -----
module aesbe_round
    import aesbe_pkg::*;
(
    input  logic [BLK_W-1:0] i_state,
    input  logic             i_mix,
    input  logic [BLK_W-1:0] i_key,
    output logic [BLK_W-1:0] o_state
);

    logic [7:0] t [16];
    logic [7:0] m [16];

    // SubBytes + ShiftRows, then optional MixColumns, then AddRoundKey
    always_comb begin
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[4*c+r] = SBOX[blk_byte(i_state, 4*((c+r)%4)+r)];
            end
        end
        for (int c = 0; c < 4; c++) begin
            m[4*c]   = xtime(t[4*c]) ^ xtime(t[4*c+1]) ^ t[4*c+1] ^ t[4*c+2] ^ t[4*c+3];
            m[4*c+1] = t[4*c] ^ xtime(t[4*c+1]) ^ xtime(t[4*c+2]) ^ t[4*c+2] ^ t[4*c+3];
            m[4*c+2] = t[4*c] ^ t[4*c+1] ^ xtime(t[4*c+2]) ^ xtime(t[4*c+3]) ^ t[4*c+3];
            m[4*c+3] = xtime(t[4*c]) ^ t[4*c] ^ t[4*c+1] ^ t[4*c+2] ^ xtime(t[4*c+3]);
        end
        for (int i = 0; i < 16; i++) begin
            o_state[BLK_W-1-8*i -: 8] = (i_mix ? m[i] : t[i]) ^ i_key[BLK_W-1-8*i -: 8];
        end
    end

endmodule
